// ===== sv/acc_pkg.sv =====
// Shared types, constants and the divider step function of the accumulator ALU.
package acc_pkg;

    localparam int W  = 32;
    localparam int SW = $clog2(W + 2);
    localparam int KW = $clog2(W);

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_AND  = 4'd4;
    localparam logic [3:0] CMD_OR   = 4'd5;
    localparam logic [3:0] CMD_XOR  = 4'd6;
    localparam logic [3:0] CMD_ROTL = 4'd7;
    localparam logic [3:0] CMD_ROTR = 4'd8;
    localparam logic [3:0] CMD_SHL  = 4'd9;
    localparam logic [3:0] CMD_SHR  = 4'd10;
    localparam logic [3:0] CMD_CMP  = 4'd11;

    localparam logic [1:0] CMP_NONE = 2'd0;
    localparam logic [1:0] CMP_EQ   = 2'd1;
    localparam logic [1:0] CMP_GT   = 2'd2;
    localparam logic [1:0] CMP_LT   = 2'd3;

    // Everything about an item that travels beside the divider.
    typedef struct packed {
        logic [W-1:0] res;
        logic         wb;
        logic         ovf;
        logic         carry;
        logic [1:0]   cmp;
        logic         derr;
        logic         is_div;
        logic         qneg;
    } t_side;

    // Divider working set: partial remainder, dividend turning into quotient, divisor.
    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] dq;
        logic [W-1:0] dvs;
    } t_divw;

    // One restoring division step: one quotient bit.
    function automatic t_divw div_step(input t_divw d);
        t_divw      o;
        logic [W:0] t;
        logic [W:0] diff;
        o    = d;
        t    = {d.rem, d.dq[W-1]};
        diff = t - {1'b0, d.dvs};
        if (!diff[W]) begin
            o.rem = diff[W-1:0];
            o.dq  = {d.dq[W-2:0], 1'b1};
        end else begin
            o.rem = t[W-1:0];
            o.dq  = {d.dq[W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== sv/acc_front.sv =====
// Front stages: operand decode, add/sub/logic/shift/compare results, multiply and its flags.
module acc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [3:0]                  i_command,
    input  logic signed [acc_pkg::W-1:0] i_accumulator,
    input  logic signed [acc_pkg::W-1:0] i_operand,
    output logic                        o_valid,
    output acc_pkg::t_side              o_side,
    output acc_pkg::t_divw              o_div
);

    localparam int W = acc_pkg::W;

    logic [W-1:0]     a, b, mag, ua;
    logic             bneg, left;
    logic [W:0]       sum, dif;
    logic [2*W-1:0]   prod, dbl;
    logic [acc_pkg::KW-1:0] k;
    logic [acc_pkg::SW-1:0] shl_amt, shr_amt;
    logic [2*W+1:0]   shl_y;
    acc_pkg::t_side   n_side;
    acc_pkg::t_divw   n_div;

    logic             r1_valid, r1_mul;
    acc_pkg::t_side   r1_side;
    acc_pkg::t_divw   r1_div;
    logic [2*W-1:0]   r1_prod;
    logic             r2_valid;
    acc_pkg::t_side   r2_side;
    acc_pkg::t_divw   r2_div;
    acc_pkg::t_side   n2_side;

    always_comb begin
        a    = i_accumulator;
        b    = i_operand;
        bneg = b[W-1];
        mag  = bneg ? (~b + 1'b1) : b;
        ua   = a[W-1] ? (~a + 1'b1) : a;
        sum  = {a[W-1], a} + {b[W-1], b};
        dif  = {a[W-1], a} - {b[W-1], b};
        prod = (2*W)'($signed(i_accumulator) * $signed(i_operand));
        k    = acc_pkg::KW'(mag % W);
        dbl  = {a, a};
        left = (i_command == acc_pkg::CMD_ROTL) != bneg;
        if (bneg) begin
            shl_amt = '0;
        end else if (b > W'(W)) begin
            shl_amt = acc_pkg::SW'(W + 1);
        end else begin
            shl_amt = b[acc_pkg::SW-1:0];
        end
        if (bneg) begin
            shr_amt = '0;
        end else if (b >= W'(W)) begin
            shr_amt = acc_pkg::SW'(W - 1);
        end else begin
            shr_amt = b[acc_pkg::SW-1:0];
        end
        shl_y = {{(W+2){1'b0}}, a} << shl_amt;

        n_side     = '0;
        n_side.res = a;
        n_div      = '0;
        n_div.dq   = ua;
        n_div.dvs  = mag;
        case (i_command)
            acc_pkg::CMD_ADD: begin
                n_side.res   = sum[W-1:0];
                n_side.wb    = 1'b1;
                n_side.ovf   = sum[W] ^ sum[W-1];
                n_side.carry = (sum[W] ^ sum[W-1]) & sum[W];
            end
            acc_pkg::CMD_SUB: begin
                n_side.res   = dif[W-1:0];
                n_side.wb    = 1'b1;
                n_side.ovf   = dif[W] ^ dif[W-1];
                n_side.carry = (dif[W] ^ dif[W-1]) & dif[W];
            end
            acc_pkg::CMD_MUL: begin
                n_side.wb = 1'b1;
            end
            acc_pkg::CMD_DIV: begin
                if (b == '0) begin
                    n_side.derr = 1'b1;
                end else begin
                    n_side.wb     = 1'b1;
                    n_side.is_div = 1'b1;
                    n_side.qneg   = a[W-1] ^ bneg;
                end
            end
            acc_pkg::CMD_AND: begin
                n_side.res = a & b;
                n_side.wb  = 1'b1;
            end
            acc_pkg::CMD_OR: begin
                n_side.res = a | b;
                n_side.wb  = 1'b1;
            end
            acc_pkg::CMD_XOR: begin
                n_side.res = a ^ b;
                n_side.wb  = 1'b1;
            end
            acc_pkg::CMD_ROTL, acc_pkg::CMD_ROTR: begin
                if (left) begin
                    n_side.res = dbl[2*W-1-k -: W];
                end else begin
                    n_side.res = dbl[k +: W];
                end
                n_side.wb = 1'b1;
            end
            acc_pkg::CMD_SHL: begin
                n_side.res   = shl_y[W-1:0];
                n_side.wb    = 1'b1;
                n_side.ovf   = 1'b1;
                n_side.carry = shl_y[W];
            end
            acc_pkg::CMD_SHR: begin
                n_side.res = $signed(i_accumulator) >>> shr_amt;
                n_side.wb  = 1'b1;
            end
            acc_pkg::CMD_CMP: begin
                if (a == b) begin
                    n_side.cmp = acc_pkg::CMP_EQ;
                end else if ($signed(i_accumulator) > $signed(i_operand)) begin
                    n_side.cmp = acc_pkg::CMP_GT;
                end else begin
                    n_side.cmp = acc_pkg::CMP_LT;
                end
            end
            default: begin
                n_side.res = a;
            end
        endcase
    end

    // The product is registered before its overflow check in the second stage.
    always_comb begin
        n2_side = r1_side;
        if (r1_mul) begin
            n2_side.res   = r1_prod[W-1:0];
            n2_side.ovf   = !((&r1_prod[2*W-1:W-1]) || !(|r1_prod[2*W-1:W-1]));
            n2_side.carry = n2_side.ovf & r1_prod[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r1_side <= n_side;
            r1_div  <= n_div;
            r1_prod <= prod;
            r1_mul  <= (i_command == acc_pkg::CMD_MUL);
            r2_side <= n2_side;
            r2_div  <= r1_div;
        end
    end

    assign o_valid = r2_valid;
    assign o_side  = r2_side;
    assign o_div   = r2_div;

endmodule

// ===== sv/acc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; other items ride alongside.
module acc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  acc_pkg::t_side i_side,
    input  acc_pkg::t_divw i_div,
    output logic           o_valid,
    output acc_pkg::t_side o_side,
    output acc_pkg::t_divw o_div
);

    localparam int W = acc_pkg::W;

    logic           r_valid [W];
    acc_pkg::t_side r_side  [W];
    acc_pkg::t_divw r_div   [W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < W; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int i = 1; i < W; i++) begin
                r_valid[i] <= r_valid[i-1];
            end
        end
        if (i_en) begin
            r_side[0] <= i_side;
            r_div[0]  <= acc_pkg::div_step(i_div);
            for (int i = 1; i < W; i++) begin
                r_side[i] <= r_side[i-1];
                r_div[i]  <= acc_pkg::div_step(r_div[i-1]);
            end
        end
    end

    assign o_valid = r_valid[W-1];
    assign o_side  = r_side[W-1];
    assign o_div   = r_div[W-1];

endmodule

// ===== sv/accumulator_alu_with_flags.sv =====
// Top level of the accumulator ALU: front stages, divider pipeline and flag output stage.
// Throughput is one item per cycle while the output is not stalled; the 32-stage divider sets the depth.
// A stall at the output while a result is valid holds the whole pipeline; o_stall follows it in the same cycle.
// Reset is synchronous, active low, and clears only the valid bits of every stage.
module accumulator_alu_with_flags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [3:0]                   i_command,
    input  logic signed [acc_pkg::W-1:0] i_accumulator,
    input  logic signed [acc_pkg::W-1:0] i_operand,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [acc_pkg::W-1:0] o_result,
    output logic                         o_write_back,
    output logic                         o_zero_flag,
    output logic                         o_sign_flag,
    output logic                         o_parity_flag,
    output logic                         o_overflow_flag,
    output logic                         o_carry_flag,
    output logic [1:0]                   o_compare_code,
    output logic                         o_divide_error
);

    localparam int W = acc_pkg::W;

    logic           en;
    logic           f_valid, d_valid;
    acc_pkg::t_side f_side, d_side, n_side;
    acc_pkg::t_divw f_div, d_div;
    logic [W-1:0]   q;

    logic           r_valid;
    acc_pkg::t_side r_side;
    logic           r_zero, r_sign, r_par;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    acc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_command     (i_command),
        .i_accumulator (i_accumulator),
        .i_operand     (i_operand),
        .o_valid       (f_valid),
        .o_side        (f_side),
        .o_div         (f_div)
    );

    acc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .i_div   (f_div),
        .o_valid (d_valid),
        .o_side  (d_side),
        .o_div   (d_div)
    );

    // Quotient magnitude is at most 2^(W-1); only a positive 2^(W-1) overflows.
    always_comb begin
        n_side = d_side;
        q      = d_div.dq;
        if (d_side.is_div) begin
            n_side.res   = d_side.qneg ? (~q + 1'b1) : q;
            n_side.ovf   = !d_side.qneg && q[W-1];
            n_side.carry = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_valid;
        end
        if (en) begin
            r_side <= n_side;
            r_zero <= n_side.wb && (n_side.res == '0);
            r_sign <= n_side.wb && n_side.res[W-1];
            r_par  <= n_side.wb && (^n_side.res);
        end
    end

    assign o_valid         = r_valid;
    assign o_result        = r_side.res;
    assign o_write_back    = r_side.wb;
    assign o_zero_flag     = r_zero;
    assign o_sign_flag     = r_sign;
    assign o_parity_flag   = r_par;
    assign o_overflow_flag = r_side.ovf;
    assign o_carry_flag    = r_side.carry;
    assign o_compare_code  = r_side.cmp;
    assign o_divide_error  = r_side.derr;

    a_derr_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> !o_write_back)
        else $error("divide error item marked for write-back");
    a_cmp_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_compare_code != acc_pkg::CMP_NONE)) |-> !o_write_back)
        else $error("compare item marked for write-back");
    a_zero_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_flag) |-> (o_result == '0 && !o_sign_flag && !o_parity_flag))
        else $error("zero flag disagrees with result");

endmodule

// ===== dv/tb_accumulator_alu_with_flags.sv =====
// Testbench of the accumulator ALU: directed and random items checked against a flag predictor.
`timescale 1ns / 100ps

module tb_accumulator_alu_with_flags;

    localparam int W = acc_pkg::W;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [W-1:0] result;
        logic         write_back;
        logic         zero_flag;
        logic         sign_flag;
        logic         parity_flag;
        logic         overflow_flag;
        logic         carry_flag;
        logic [1:0]   compare_code;
        logic         divide_error;
    } t_alu_out;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [3:0]          i_command;
    logic signed [W-1:0] i_accumulator;
    logic signed [W-1:0] i_operand;
    logic                o_valid;
    logic                i_stall;
    logic signed [W-1:0] o_result;
    logic                o_write_back;
    logic                o_zero_flag;
    logic                o_sign_flag;
    logic                o_parity_flag;
    logic                o_overflow_flag;
    logic                o_carry_flag;
    logic [1:0]          o_compare_code;
    logic                o_divide_error;

    t_alu_out expected_results[$];
    int       error_count;
    int       idle_cycles;
    bit       no_gaps;

    accumulator_alu_with_flags u_dut (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Fills result, zero, sign and parity from a W-bit value with write-back set.
    function automatic t_alu_out plain_result(input logic [W-1:0] r);
        t_alu_out o;
        o             = '0;
        o.result      = r;
        o.write_back  = 1'b1;
        o.zero_flag   = (r == '0);
        o.sign_flag   = r[W-1];
        o.parity_flag = ^r;
        return o;
    endfunction

    // Exact result held in 2W bits; overflow when it does not fit in W bits.
    function automatic t_alu_out exact_result(input logic signed [2*W-1:0] e);
        t_alu_out o;
        logic     ovf;
        o               = plain_result(e[W-1:0]);
        ovf             = (e != {{W{e[W-1]}}, e[W-1:0]});
        o.overflow_flag = ovf;
        o.carry_flag    = ovf & e[W];
        return o;
    endfunction

    function automatic t_alu_out predict_alu(input logic [3:0] cmd, input logic [W-1:0] a,
                                             input logic [W-1:0] b);
        t_alu_out                o;
        logic signed [2*W-1:0]   sa;
        logic signed [2*W-1:0]   sb;
        logic [W-1:0]            mag;
        logic [W-1:0]            ua;
        logic [W-1:0]            rot;
        logic [2*W-1:0]          q;
        logic [2*W-1:0]          dbl;
        int unsigned             k;
        int unsigned             s;
        bit                      left;
        sa = {{W{a[W-1]}}, a};
        sb = {{W{b[W-1]}}, b};
        mag = b[W-1] ? -b : b;
        o = '0;
        o.result = a;
        case (cmd)
            acc_pkg::CMD_ADD: o = exact_result(sa + sb);
            acc_pkg::CMD_SUB: o = exact_result(sa - sb);
            acc_pkg::CMD_MUL: o = exact_result(sa * sb);
            acc_pkg::CMD_DIV: begin
                if (b == '0) begin
                    o.divide_error = 1'b1;
                end else begin
                    ua = a[W-1] ? -a : a;
                    q  = {{W{1'b0}}, ua / mag};
                    if (a[W-1] != b[W-1]) q = -q;
                    o = exact_result(q);
                end
            end
            acc_pkg::CMD_AND: o = plain_result(a & b);
            acc_pkg::CMD_OR:  o = plain_result(a | b);
            acc_pkg::CMD_XOR: o = plain_result(a ^ b);
            acc_pkg::CMD_ROTL, acc_pkg::CMD_ROTR: begin
                k    = mag % W;
                left = (cmd == acc_pkg::CMD_ROTL) != b[W-1];
                if (!left && k != 0) k = W - k;
                dbl  = {a, a} << k;
                rot  = dbl[2*W-1:W];
                o    = plain_result(rot);
            end
            acc_pkg::CMD_SHL: begin
                s = b[W-1] ? 0 : b;
                o = plain_result(s >= W ? '0 : a << s);
                o.overflow_flag = 1'b1;
                if (s >= 1 && s <= W) o.carry_flag = a[W-s];
            end
            acc_pkg::CMD_SHR: begin
                s = b[W-1] ? 0 : b;
                if (s >= W) s = W - 1;
                o = plain_result($signed(a) >>> s);
            end
            acc_pkg::CMD_CMP: begin
                if (a == b) o.compare_code = acc_pkg::CMP_EQ;
                else if ($signed(a) > $signed(b)) o.compare_code = acc_pkg::CMP_GT;
                else o.compare_code = acc_pkg::CMP_LT;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Valid stays high between back-to-back items and drops only during a gap.
    task automatic send_item(input logic [3:0] cmd, input logic [W-1:0] a,
                             input logic [W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_accumulator <= a;
        i_operand     <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.push_back(predict_alu(cmd, a, b));
    endtask

    // Receiver: a random stall is drawn per result, then released until that result is taken.
    initial begin
        int hold;
        forever begin
            hold = no_gaps ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_alu_out exp_out;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                error_count++;
            end else begin
                exp_out = expected_results.pop_front();
                if (o_result !== exp_out.result) begin
                    $error("result exp %h got %h", exp_out.result, o_result); error_count++;
                end
                if (o_write_back !== exp_out.write_back) begin
                    $error("write_back exp %b got %b", exp_out.write_back, o_write_back);
                    error_count++;
                end
                if (o_zero_flag !== exp_out.zero_flag) begin
                    $error("zero_flag exp %b got %b", exp_out.zero_flag, o_zero_flag);
                    error_count++;
                end
                if (o_sign_flag !== exp_out.sign_flag) begin
                    $error("sign_flag exp %b got %b", exp_out.sign_flag, o_sign_flag);
                    error_count++;
                end
                if (o_parity_flag !== exp_out.parity_flag) begin
                    $error("parity_flag exp %b got %b", exp_out.parity_flag, o_parity_flag);
                    error_count++;
                end
                if (o_overflow_flag !== exp_out.overflow_flag) begin
                    $error("overflow_flag exp %b got %b", exp_out.overflow_flag,
                           o_overflow_flag);
                    error_count++;
                end
                if (o_carry_flag !== exp_out.carry_flag) begin
                    $error("carry_flag exp %b got %b", exp_out.carry_flag, o_carry_flag);
                    error_count++;
                end
                if (o_compare_code !== exp_out.compare_code) begin
                    $error("compare_code exp %d got %d", exp_out.compare_code,
                           o_compare_code);
                    error_count++;
                end
                if (o_divide_error !== exp_out.divide_error) begin
                    $error("divide_error exp %b got %b", exp_out.divide_error,
                           o_divide_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_accumulator_alu_with_flags: FAIL");
            $finish;
        end
    end

    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ALL_ONE = '1;

    function automatic logic [W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 70) - 35;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_arithmetic();
        send_item(acc_pkg::CMD_ADD, MAX_POS, 1);
        send_item(acc_pkg::CMD_ADD, MAX_NEG, ALL_ONE);
        send_item(acc_pkg::CMD_SUB, MAX_NEG, 1);
        send_item(acc_pkg::CMD_SUB, 5, 5);
        send_item(acc_pkg::CMD_MUL, MAX_NEG, MAX_NEG);
        send_item(acc_pkg::CMD_MUL, ALL_ONE, 7);
        send_item(acc_pkg::CMD_DIV, MAX_NEG, ALL_ONE);
        send_item(acc_pkg::CMD_DIV, 7, 0);
        send_item(acc_pkg::CMD_DIV, -7, 2);
    endtask

    task automatic test_logic_and_shifts();
        send_item(acc_pkg::CMD_AND, ALL_ONE, MAX_POS);
        send_item(acc_pkg::CMD_OR, 0, 0);
        send_item(acc_pkg::CMD_XOR, ALL_ONE, MAX_NEG);
        send_item(acc_pkg::CMD_ROTL, 32'h8000_0001, -1);
        send_item(acc_pkg::CMD_ROTR, 32'h8000_0001, 33);
        send_item(acc_pkg::CMD_SHL, 32'h0000_0001, W);
        send_item(acc_pkg::CMD_SHL, ALL_ONE, W + 1);
        send_item(acc_pkg::CMD_SHL, 32'h1234_5678, -3);
        send_item(acc_pkg::CMD_SHR, MAX_NEG, W);
        send_item(acc_pkg::CMD_SHR, MAX_NEG, 4);
        send_item(acc_pkg::CMD_SHR, 32'h0F00_0000, ALL_ONE);
    endtask

    task automatic test_compare_and_unknown();
        send_item(acc_pkg::CMD_CMP, MAX_NEG, MAX_POS);
        send_item(acc_pkg::CMD_CMP, MAX_POS, MAX_NEG);
        send_item(acc_pkg::CMD_CMP, 9, 9);
        send_item(4'd12, 3, 4);
        send_item(4'd15, MAX_NEG, 1);
    endtask

    task automatic test_random_items();
        logic [3:0] cmd;
        logic [W-1:0] opnd;
        for (int n = 0; n < 650; n++) begin
            no_gaps = (n % 100) >= 80;
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
            opnd = random_word();
            if (cmd >= acc_pkg::CMD_ROTL && cmd <= acc_pkg::CMD_SHR && $urandom_range(0, 1))
                opnd = $urandom_range(0, 70) - 35;
            send_item(cmd, random_word(), opnd);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        no_gaps       = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= '0;
        i_accumulator <= '0;
        i_operand     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arithmetic();
        test_logic_and_shifts();
        test_compare_and_unknown();
        test_random_items();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_accumulator_alu_with_flags: PASS");
        end else begin
            $display("tb_accumulator_alu_with_flags: FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/acc_pkg.sv
sv/acc_front.sv
sv/acc_div.sv
sv/accumulator_alu_with_flags.sv
dv/tb_accumulator_alu_with_flags.sv
